[rtl/bpmd_pkg.sv]
// Shared types, register indexes, operation codes and constants of the balance drive.
`default_nettype none

package bpmd_pkg;

	localparam int CFG_W = 10;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_SETPOINT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN_Q8    = 3'd4;
	localparam logic [IDX_W-1:0] REG_INT_LIMIT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEAD_BAND  = 3'd6;
	localparam logic [IDX_W-1:0] REG_TILT_LIMIT = 3'd7;

	localparam logic [8:0] RST_SETPOINT   = 9'd0;
	localparam logic [3:0] RST_GAIN_P     = 4'd3;
	localparam logic [3:0] RST_GAIN_I     = 4'd1;
	localparam logic [3:0] RST_GAIN_D     = 4'd6;
	localparam logic [9:0] RST_GAIN_Q8    = 10'd358;
	localparam logic [7:0] RST_INT_LIMIT  = 8'd20;
	localparam logic [7:0] RST_DEAD_BAND  = 8'd30;
	localparam logic [7:0] RST_TILT_LIMIT = 8'd40;

	localparam logic [23:0] SUM_MAX = 24'h7F_FFFF;
	localparam logic [23:0] SUM_MIN = 24'h80_0000;

	localparam logic [7:0]         DUTY_FLOOR = 8'd100;
	localparam logic signed [10:0] DUTY_SPAN  = 11'sd155;
	localparam logic [7:0]         DUTY_FULL  = 8'hFF;

	// datapath operations, one per sequencer step
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_P    = 3'd1;
	localparam logic [2:0] OP_I    = 3'd2;
	localparam logic [2:0] OP_D    = 3'd3;
	localparam logic [2:0] OP_G    = 3'd4;
	localparam logic [2:0] OP_DRV  = 3'd5;
	localparam logic [2:0] OP_NUM  = 3'd6;
	localparam logic [2:0] OP_DIV  = 3'd7;

	typedef struct packed {
		logic       capture;
		logic [2:0] op;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic short_path;
	} sts_t;

endpackage

`default_nettype wire

[rtl/bpmd_ctrl.sv]
// Sequencer of the balance drive: steps the shared multiplier, divider and result register.
`default_nettype none

module bpmd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire bpmd_pkg::sts_t sts,
	output bpmd_pkg::cmd_t     cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_P    = 4'd1;
	localparam logic [3:0] ST_I    = 4'd2;
	localparam logic [3:0] ST_D    = 4'd3;
	localparam logic [3:0] ST_G    = 4'd4;
	localparam logic [3:0] ST_DRV  = 4'd5;
	localparam logic [3:0] ST_NUM  = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic       load;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.load_out = load;
		case (state_q)
			ST_P:    cmd.op = bpmd_pkg::OP_P;
			ST_I:    cmd.op = bpmd_pkg::OP_I;
			ST_D:    cmd.op = bpmd_pkg::OP_D;
			ST_G:    cmd.op = bpmd_pkg::OP_G;
			ST_DRV:  cmd.op = bpmd_pkg::OP_DRV;
			ST_NUM:  cmd.op = bpmd_pkg::OP_NUM;
			ST_DIV:  cmd.op = bpmd_pkg::OP_DIV;
			default: cmd.op = bpmd_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_P;
				ST_P:    state_q <= ST_I;
				ST_I:    state_q <= ST_D;
				ST_D:    state_q <= ST_G;
				ST_G:    state_q <= ST_DRV;
				ST_DRV: begin
					state_q <= sts.short_path ? ST_FIN : ST_NUM;
				end
				ST_NUM: begin
					state_q <= ST_DIV;
					step_q  <= 3'd7;
				end
				ST_DIV: begin
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0)
						state_q <= ST_FIN;
				end
				ST_FIN: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/bpmd_dp.sv]
// Datapath of the balance drive: registers, PID state, shared multiplier, duty divider.
`default_nettype none

module bpmd_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bpmd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [bpmd_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic signed [8:0]            pitch_deg,
	input  wire bpmd_pkg::cmd_t               cmd,
	output bpmd_pkg::sts_t                    sts,
	output logic                              forward,
	output logic [7:0]                        duty,
	output logic                              tilted_out
);

	logic signed [8:0] setpoint_q;
	logic [3:0]        gain_p_q, gain_i_q, gain_d_q;
	logic [9:0]        gain_q8_q;
	logic [7:0]        int_limit_q, dead_band_q, tilt_limit_q;

	logic signed [23:0] sum_q;
	logic signed [9:0]  prev_q;

	logic signed [9:0]  err_q;
	logic               tilted_q;
	logic signed [10:0] diff_q;
	logic signed [16:0] acc_q;
	logic signed [27:0] prod_q;
	logic [7:0]         mag_q;
	logic               fwd_q;
	logic               short_q;
	logic [7:0]         sduty_q;
	logic [15:0]        rem_q;
	logic [15:0]        den_sh_q;
	logic [7:0]         quot_q;

	logic signed [9:0]  err_w;
	logic signed [9:0]  p10, t10, psum;
	logic               tilted_w;
	logic signed [24:0] sum_next;
	logic signed [23:0] lim_s;
	logic signed [8:0]  iclamp;
	logic signed [16:0] ma;
	logic signed [10:0] mb;
	logic signed [27:0] prod;
	logic signed [27:0] biased;
	logic signed [19:0] scaled;
	logic signed [8:0]  cl, ncl;
	logic [7:0]         mag_w;
	logic               fwd_w;
	logic               below;
	logic [7:0]         den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= bpmd_pkg::RST_SETPOINT;
			gain_p_q     <= bpmd_pkg::RST_GAIN_P;
			gain_i_q     <= bpmd_pkg::RST_GAIN_I;
			gain_d_q     <= bpmd_pkg::RST_GAIN_D;
			gain_q8_q    <= bpmd_pkg::RST_GAIN_Q8;
			int_limit_q  <= bpmd_pkg::RST_INT_LIMIT;
			dead_band_q  <= bpmd_pkg::RST_DEAD_BAND;
			tilt_limit_q <= bpmd_pkg::RST_TILT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				bpmd_pkg::REG_SETPOINT:   setpoint_q   <= cfg_data[8:0];
				bpmd_pkg::REG_GAIN_P:     gain_p_q     <= cfg_data[3:0];
				bpmd_pkg::REG_GAIN_I:     gain_i_q     <= cfg_data[3:0];
				bpmd_pkg::REG_GAIN_D:     gain_d_q     <= cfg_data[3:0];
				bpmd_pkg::REG_GAIN_Q8:    gain_q8_q    <= cfg_data[9:0];
				bpmd_pkg::REG_INT_LIMIT:  int_limit_q  <= cfg_data[7:0];
				bpmd_pkg::REG_DEAD_BAND:  dead_band_q  <= cfg_data[7:0];
				bpmd_pkg::REG_TILT_LIMIT: tilt_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// error and tilt window at capture
	assign err_w    = {setpoint_q[8], setpoint_q} - {pitch_deg[8], pitch_deg};
	assign p10      = {pitch_deg[8], pitch_deg};
	assign t10      = {2'b00, tilt_limit_q};
	assign psum     = p10 + t10;
	assign tilted_w = (psum <= 10'sd0) || (p10 >= t10);

	assign sum_next = {sum_q[23], sum_q} + {{15{err_q[9]}}, err_q};

	// integral input held to +/- limit
	assign lim_s = {16'b0, int_limit_q};
	always_comb begin
		if (sum_q > lim_s)
			iclamp = {1'b0, int_limit_q};
		else if (sum_q < -lim_s)
			iclamp = -{1'b0, int_limit_q};
		else
			iclamp = sum_q[8:0];
	end

	always_comb begin
		case (cmd.op)
			bpmd_pkg::OP_P: begin
				ma = {{7{err_q[9]}}, err_q};
				mb = {7'b0, gain_p_q};
			end
			bpmd_pkg::OP_I: begin
				ma = {{8{iclamp[8]}}, iclamp};
				mb = {7'b0, gain_i_q};
			end
			bpmd_pkg::OP_D: begin
				ma = {{6{diff_q[10]}}, diff_q};
				mb = {7'b0, gain_d_q};
			end
			bpmd_pkg::OP_G: begin
				ma = acc_q;
				mb = {1'b0, gain_q8_q};
			end
			bpmd_pkg::OP_NUM: begin
				ma = {9'b0, 8'(mag_q - dead_band_q)};
				mb = bpmd_pkg::DUTY_SPAN;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;

	// divide by 256 toward zero, clamp, negate, window
	assign biased = prod_q[27] ? prod_q + 28'sd255 : prod_q;
	assign scaled = biased[27:8];
	always_comb begin
		if (scaled > 20'sd255)
			cl = 9'sd255;
		else if (scaled < -20'sd255)
			cl = -9'sd255;
		else
			cl = scaled[8:0];
	end
	assign ncl   = -cl;
	assign mag_w = tilted_q ? 8'd0 : (cl[8] ? ncl[7:0] : cl[7:0]);
	assign fwd_w = tilted_q || cl[8] || (cl == 9'sd0);
	assign below = mag_w < dead_band_q;
	assign sts.short_path = below || (dead_band_q == 8'hFF);

	assign den = 8'hFF - dead_band_q;

	// PID state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (cmd.op == bpmd_pkg::OP_P) begin
			if (sum_next[24] != sum_next[23])
				sum_q <= sum_next[24] ? bpmd_pkg::SUM_MIN : bpmd_pkg::SUM_MAX;
			else
				sum_q <= sum_next[23:0];
			prev_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			err_q    <= err_w;
			tilted_q <= tilted_w;
		end
		case (cmd.op)
			bpmd_pkg::OP_P: begin
				acc_q  <= prod[16:0];
				diff_q <= {err_q[9], err_q} - {prev_q[9], prev_q};
			end
			bpmd_pkg::OP_I: acc_q <= acc_q + prod[16:0];
			bpmd_pkg::OP_D: acc_q <= acc_q + prod[16:0];
			bpmd_pkg::OP_G: prod_q <= prod;
			bpmd_pkg::OP_DRV: begin
				mag_q   <= mag_w;
				fwd_q   <= fwd_w;
				short_q <= sts.short_path;
				sduty_q <= below ? 8'd0 : bpmd_pkg::DUTY_FULL;
			end
			bpmd_pkg::OP_NUM: begin
				rem_q    <= prod[15:0];
				den_sh_q <= {1'b0, den, 7'b0};
				quot_q   <= '0;
			end
			bpmd_pkg::OP_DIV: begin
				// restoring step, one quotient bit
				if (rem_q >= den_sh_q) begin
					rem_q  <= rem_q - den_sh_q;
					quot_q <= {quot_q[6:0], 1'b1};
				end else begin
					quot_q <= {quot_q[6:0], 1'b0};
				end
				den_sh_q <= {1'b0, den_sh_q[15:1]};
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			forward    <= fwd_q;
			tilted_out <= tilted_q;
			duty       <= short_q ? sduty_q : bpmd_pkg::DUTY_FLOOR + quot_q;
		end
	end

endmodule

`default_nettype wire

[rtl/balance_pid_motor_drive.sv]
// Top level of the balance PID motor drive: sequencer, datapath and checks.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | pitch_deg[8:0] signed
//  out      | out_valid/out_stall | forward, duty[7:0], tilted_out
//  cfg      | cfg_we              | cfg_index[2:0], cfg_data[9:0]
//
// One item at a time: the next is accepted once the current result is loaded,
// whether dead band settles the duty or it needs the 8-step restoring divider.
// The P, I, D and gain products share one 17x11 multiplier, one per cycle.
// The result register holds a beat under out_stall; the next item computes
// meanwhile and waits at its end until the register frees.
// Reset loads the register defaults and clears the error sum and last error.
`default_nettype none

module balance_pid_motor_drive (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bpmd_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [bpmd_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [8:0]          pitch_deg,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            forward,
	output logic [7:0]                      duty,
	output logic                            tilted_out
);

	bpmd_pkg::cmd_t cmd;
	bpmd_pkg::sts_t sts;

	bpmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpmd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pitch_deg  (pitch_deg),
		.cmd        (cmd),
		.sts        (sts),
		.forward    (forward),
		.duty       (duty),
		.tilted_out (tilted_out)
	);

	// an accepted beat blocks the next one until its work is done
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted on back-to-back cycles");

	// a tilted beat drives zero: forward, stopped or floor duty
	a_tilt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tilted_out) |-> (forward && (duty == 8'd0 || duty == 8'd100)))
		else $error("tilted beat with nonzero drive");

	// a load never lands on a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && cmd.load_out) |-> 1'b0)
		else $error("result register overwritten under stall");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for the balance PID motor drive: directed, integral clamp and random phases.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     RUN_LIMIT = 4_000_000;
	localparam int     SETTLE    = 24;
	localparam int     PHASES    = 12;
	localparam int     PHASE_LEN = 115;
	localparam longint ACC_MAX   = 64'sd8388607;
	localparam longint ACC_MIN   = -64'sd8388608;

	typedef struct {
		logic       forward;
		logic [7:0] duty;
		logic       tilted;
	} drive_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bpmd_pkg::IDX_W-1:0]     cfg_index;
	logic [bpmd_pkg::CFG_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic signed [8:0]              pitch_deg;
	logic                           out_valid;
	logic                           out_stall;
	logic                           forward;
	logic [7:0]                     duty;
	logic                           tilted_out;

	// controller copy: registers and loop state
	logic signed [8:0]  set_pt;
	logic [3:0]         kp, ki, kd;
	logic [9:0]         k_scale;
	logic [7:0]         i_lim, dband, tilt_lim;
	logic signed [9:0]  err_prev;
	logic signed [23:0] err_acc;

	drive_t drive_due[$];
	int     mismatches;
	bit     gaps_on;

	balance_pid_motor_drive i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic drive_t next_drive(input logic signed [8:0] pitch);
		drive_t r;
		longint err, acc, lim, i_in, pid, scaled, drv, mag, db, tl;
		err = longint'(set_pt) - longint'(pitch);
		acc = longint'(err_acc) + err;
		if (acc > ACC_MAX)
			acc = ACC_MAX;
		else if (acc < ACC_MIN)
			acc = ACC_MIN;
		lim = longint'(i_lim);
		i_in = acc > lim ? lim : (acc < -lim ? -lim : acc);
		pid = longint'(kp) * err + longint'(ki) * i_in
			+ longint'(kd) * (err - longint'(err_prev));
		err_acc = acc[23:0];
		err_prev = err[9:0];
		// signed division truncates toward zero
		scaled = pid * longint'(k_scale) / 256;
		if (scaled > 255)
			scaled = 255;
		else if (scaled < -255)
			scaled = -255;
		drv = -scaled;
		tl = longint'(tilt_lim);
		r.tilted = (longint'(pitch) <= -tl) || (longint'(pitch) >= tl);
		if (r.tilted)
			drv = 0;
		mag = drv < 0 ? -drv : drv;
		db = longint'(dband);
		if (mag < db)
			r.duty = 8'd0;
		else if (db == 255)
			r.duty = 8'd255;
		else
			r.duty = 8'(100 + (mag - db) * 155 / (255 - db));
		r.forward = drv >= 0;
		return r;
	endfunction

	// bits above the register width carry junk, the block must drop them
	task automatic write_reg(input logic [bpmd_pkg::IDX_W-1:0] idx, input int val);
		logic [bpmd_pkg::CFG_W-1:0] word;
		word = $urandom_range(0, 1023);
		case (idx)
			bpmd_pkg::REG_SETPOINT: begin
				word[8:0] = val[8:0];
				set_pt = val[8:0];
			end
			bpmd_pkg::REG_GAIN_P: begin
				word[3:0] = val[3:0];
				kp = val[3:0];
			end
			bpmd_pkg::REG_GAIN_I: begin
				word[3:0] = val[3:0];
				ki = val[3:0];
			end
			bpmd_pkg::REG_GAIN_D: begin
				word[3:0] = val[3:0];
				kd = val[3:0];
			end
			bpmd_pkg::REG_GAIN_Q8: begin
				word = val[9:0];
				k_scale = val[9:0];
			end
			bpmd_pkg::REG_INT_LIMIT: begin
				word[7:0] = val[7:0];
				i_lim = val[7:0];
			end
			bpmd_pkg::REG_DEAD_BAND: begin
				word[7:0] = val[7:0];
				dband = val[7:0];
			end
			bpmd_pkg::REG_TILT_LIMIT: begin
				word[7:0] = val[7:0];
				tilt_lim = val[7:0];
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_all(input int sp, input int p, input int i, input int d,
			input int q8, input int il, input int db, input int tl);
		write_reg(bpmd_pkg::REG_SETPOINT, sp);
		write_reg(bpmd_pkg::REG_GAIN_P, p);
		write_reg(bpmd_pkg::REG_GAIN_I, i);
		write_reg(bpmd_pkg::REG_GAIN_D, d);
		write_reg(bpmd_pkg::REG_GAIN_Q8, q8);
		write_reg(bpmd_pkg::REG_INT_LIMIT, il);
		write_reg(bpmd_pkg::REG_DEAD_BAND, db);
		write_reg(bpmd_pkg::REG_TILT_LIMIT, tl);
	endtask

	// valid stays high across back-to-back beats; drop it only for a gap
	task automatic send_pitch(input logic signed [8:0] p);
		int gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pitch_deg <= p;
		do @(posedge clk); while (in_stall);
		drive_due.push_back(next_drive(p));
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (drive_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int pick_level(input int top);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return top;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	function automatic int pick_setpoint();
		case ($urandom_range(0, 7))
			0: return -256;
			1: return 255;
			2: return -180;
			3: return 180;
			default: return int'($urandom_range(0, 120)) - 60;
		endcase
	endfunction

	function automatic int pick_dead_band();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 254;
			2: return 255;
			default: return $urandom_range(0, 120);
		endcase
	endfunction

	function automatic int pick_tilt();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 255;
			2: return 180;
			default: return $urandom_range(40, 255);
		endcase
	endfunction

	// mostly near the setpoint so the loop stays inside the window
	function automatic logic signed [8:0] pick_pitch();
		int dev;
		if ($urandom_range(0, 99) < 15)
			return 9'($urandom_range(0, 511));
		dev = int'($urandom_range(0, 50)) - 25;
		return 9'(int'(set_pt) + dev);
	endfunction

	task automatic test_reset_defaults();
		send_pitch(9'sd0);
		send_pitch(9'sd39);
		send_pitch(9'sd40);
		send_pitch(-9'sd39);
		send_pitch(-9'sd40);
		send_pitch(9'sd255);
		send_pitch(-9'sd256);
		send_pitch(9'sd12);
		send_pitch(-9'sd12);
		quiesce();
	endtask

	task automatic test_dead_band_edges();
		// zero dead band: a tilted beat still maps to the duty floor
		program_all(0, 3, 1, 6, 358, 20, 0, 40);
		send_pitch(9'sd100);
		send_pitch(9'sd0);
		quiesce();
		// full dead band: only a saturated drive gets through
		program_all(0, 15, 1, 6, 1023, 20, 255, 255);
		send_pitch(9'sd120);
		send_pitch(-9'sd120);
		send_pitch(9'sd0);
		quiesce();
		program_all(0, 3, 1, 6, 0, 20, 30, 40);
		send_pitch(9'sd10);
		send_pitch(-9'sd10);
		quiesce();
	endtask

	// probe the sum with only the integral path at unit scale
	task automatic probe_sum();
		quiesce();
		program_all(0, 0, 1, 0, 256, 255, 0, 255);
		send_pitch(9'sd0);
		send_pitch(9'sd0);
		quiesce();
	endtask

	// push the error sum past the integral limit on both sides
	task automatic test_integral_clamp();
		program_all(0, 2, 7, 3, 300, 20, 0, 255);
		repeat (6) send_pitch(-9'sd60);
		repeat (12) send_pitch(9'sd60);
		probe_sum();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < PHASES; ph++) begin
			quiesce();
			gaps_on = (ph % 5 != 3);
			program_all(pick_setpoint(), pick_level(15), pick_level(15), pick_level(15),
				pick_level(1023), pick_level(255), pick_dead_band(), pick_tilt());
			repeat (PHASE_LEN) send_pitch(pick_pitch());
		end
		gaps_on = 1'b1;
	endtask

	initial begin : drain
		int hold;
		drive_t want;
		@(posedge arst_n);
		forever begin
			hold = gaps_on ? $urandom_range(0, 7) : 0;
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (drive_due.size() == 0) begin
				$error("unexpected beat: forward %0d duty %0d tilted_out %0d",
					forward, duty, tilted_out);
				mismatches++;
			end else begin
				want = drive_due.pop_front();
				if (forward !== want.forward) begin
					$error("forward: expected %0d, got %0d", want.forward, forward);
					mismatches++;
				end
				if (duty !== want.duty) begin
					$error("duty: expected %0d, got %0d", want.duty, duty);
					mismatches++;
				end
				if (tilted_out !== want.tilted) begin
					$error("tilted_out: expected %0d, got %0d", want.tilted, tilted_out);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pitch_deg = '0;
		out_stall = 1'b1;
		mismatches = 0;
		gaps_on = 1'b1;
		set_pt = bpmd_pkg::RST_SETPOINT;
		kp = bpmd_pkg::RST_GAIN_P;
		ki = bpmd_pkg::RST_GAIN_I;
		kd = bpmd_pkg::RST_GAIN_D;
		k_scale = bpmd_pkg::RST_GAIN_Q8;
		i_lim = bpmd_pkg::RST_INT_LIMIT;
		dband = bpmd_pkg::RST_DEAD_BAND;
		tilt_lim = bpmd_pkg::RST_TILT_LIMIT;
		err_prev = '0;
		err_acc = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_dead_band_edges();
		test_integral_clamp();
		test_random_phases();
		quiesce();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/bpmd_pkg.sv
rtl/bpmd_ctrl.sv
rtl/bpmd_dp.sv
rtl/balance_pid_motor_drive.sv
tb/tb_top.sv
